FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define GKT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition must never be seen at a clock edge outside reset
`define GKT_ASSERT_NEVER(lbl, cond, msg) \
	`GKT_ASSERT(lbl, !(cond), msg)

`endif

FILE: hdl/gkt_pkg.sv
// ----------------------------------------------------------------------------
// gkt_pkg
// Item types, opcodes and status codes of the generational key table.
// ----------------------------------------------------------------------------
package gkt_pkg;

	localparam int OPCODE_W  = 3;
	localparam int IDX_W     = 6;
	localparam int KGEN_W    = 16;
	localparam int VALUE_W   = 64;
	localparam int HANDLER_W = 32;
	localparam int STATUS_W  = 2;

	localparam logic [OPCODE_W-1:0] OP_CREATE = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_DELETE = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_SET    = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_GET    = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_SWEEP  = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOFREE  = 2'd2;

	typedef struct packed {
		logic [OPCODE_W-1:0]  opcode;
		logic [IDX_W-1:0]     key_slot;
		logic [KGEN_W-1:0]    key_generation;
		logic [VALUE_W-1:0]   value;
		logic [HANDLER_W-1:0] destructor_handle;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [IDX_W-1:0]     slot_index;
		logic [KGEN_W-1:0]    slot_generation;
		logic [VALUE_W-1:0]   read_value;
		logic [HANDLER_W-1:0] handler;
		logic                 found;
		logic                 last;
	} rsp_t;

endpackage

FILE: hdl/gkt_ram.sv
// ----------------------------------------------------------------------------
// gkt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gkt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/generational_key_table.sv
// ----------------------------------------------------------------------------
// generational_key_table
// Slot table with wrapping generations and a tagged value store, both in RAM.
// Non-sweep requests read the RAMs (create via S_ALLOC); the result is
// registered in S_EXEC once the output is free. One request is held at a time.
// Sweep walks every slot through S_SW_RD and S_SW_CHK, then ends in S_SW_END.
// Reset: a clearing pass over every slot zeroes both RAMs; req_ready stays low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module generational_key_table #(
	parameter int KEYS     = 64,
	parameter int GEN_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  gkt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output gkt_pkg::rsp_t rsp
);

	import gkt_pkg::*;

	localparam int IW = $clog2(KEYS);
	localparam int CW = (GEN_BITS > KGEN_W) ? GEN_BITS : KGEN_W;
	localparam int SW = GEN_BITS + HANDLER_W;
	localparam int VW = VALUE_W + GEN_BITS;
	localparam logic [IW-1:0] LAST_IDX = IW'(KEYS - 1);

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_ALLOC  = 7'b0000100,
		S_EXEC   = 7'b0001000,
		S_SW_RD  = 7'b0010000,
		S_SW_CHK = 7'b0100000,
		S_SW_END = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	req_t req_q;
	logic [IW-1:0] ptr_q, ptr_d;
	logic [KEYS-1:0] used_q;
	logic [IW-1:0] free_idx_q, free_idx_d;
	logic full_q;
	rsp_t rsp_q, rsp_d;
	logic rsp_valid_q, rsp_load;
	rsp_t pend_q;
	logic pend_valid_q, pend_load, pend_clr;
	logic set_used, clr_used;

	logic rd_en;
	logic [IW-1:0] rd_addr;
	logic slot_we, val_we;
	logic [IW-1:0] slot_waddr, val_waddr;
	logic [SW-1:0] slot_wdata, slot_rdata;
	logic [VW-1:0] val_wdata, val_rdata;

	logic [GEN_BITS-1:0] rd_gen, rd_tag, gen_inc;
	logic [HANDLER_W-1:0] rd_handler;
	logic [VALUE_W-1:0] rd_value;
	logic [IW-1:0] req_idx;
	logic idx_ok, key_ok, out_free, accept, hit, create_commit;
	rsp_t exec_rsp, hit_rsp, end_rsp;
	logic do_create, do_delete, do_set;
	logic rsp_err, rsp_payload_ok;

	gkt_ram #(.WIDTH(SW), .DEPTH(KEYS)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (slot_rdata)
	);

	gkt_ram #(.WIDTH(VW), .DEPTH(KEYS)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (val_rdata)
	);

	assign rd_gen     = slot_rdata[SW-1 -: GEN_BITS];
	assign rd_handler = slot_rdata[HANDLER_W-1:0];
	assign rd_value   = val_rdata[VW-1 -: VALUE_W];
	assign rd_tag     = val_rdata[GEN_BITS-1:0];
	assign gen_inc    = rd_gen + GEN_BITS'(1);

	assign req_idx  = IW'(req_q.key_slot);
	assign idx_ok   = 32'(req_q.key_slot) < 32'(KEYS);
	assign key_ok   = idx_ok && used_q[req_idx];
	assign out_free = !rsp_valid_q || rsp_ready;
	assign accept   = req_valid && req_ready;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// lowest free slot, registered so it is settled before an alloc read
	always_comb begin
		free_idx_d = '0;
		for (int i = KEYS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_idx_d = IW'(i);
			end
		end
	end

	// single-item result of a table operation
	always_comb begin
		exec_rsp = '0;
		exec_rsp.last = 1'b1;
		do_create = 1'b0;
		do_delete = 1'b0;
		do_set = 1'b0;
		unique case (req_q.opcode)
			OP_CREATE: begin
				if (full_q) begin
					exec_rsp.status = ST_NOFREE;
				end else begin
					do_create = 1'b1;
					exec_rsp.slot_index = IDX_W'(free_idx_q);
					exec_rsp.slot_generation = KGEN_W'(gen_inc);
				end
			end
			OP_DELETE: begin
				do_delete = key_ok;
				exec_rsp.status = key_ok ? ST_OK : ST_INVALID;
			end
			OP_SET: begin
				do_set = key_ok;
				exec_rsp.status = key_ok ? ST_OK : ST_INVALID;
			end
			OP_GET: begin
				if (idx_ok && (CW'(rd_tag) == CW'(req_q.key_generation))) begin
					exec_rsp.read_value = rd_value;
				end
			end
			default: begin
				exec_rsp.status = ST_INVALID;
			end
		endcase
	end

	assign hit = (rd_value != '0) && used_q[ptr_q] && (rd_tag == rd_gen)
		&& (rd_handler != '0);

	always_comb begin
		hit_rsp = '0;
		hit_rsp.slot_index = IDX_W'(ptr_q);
		hit_rsp.slot_generation = KGEN_W'(rd_gen);
		hit_rsp.read_value = rd_value;
		hit_rsp.handler = rd_handler;
		hit_rsp.found = 1'b1;
		end_rsp = pend_valid_q ? pend_q : '0;
		end_rsp.last = 1'b1;
	end

	always_comb begin
		state_d = state_q;
		ptr_d = ptr_q;
		rd_en = 1'b0;
		rd_addr = ptr_q;
		slot_we = 1'b0;
		slot_waddr = free_idx_q;
		slot_wdata = {gen_inc, req_q.destructor_handle};
		val_we = 1'b0;
		val_waddr = req_idx;
		val_wdata = {req_q.value, rd_gen};
		rsp_load = 1'b0;
		rsp_d = exec_rsp;
		pend_load = 1'b0;
		pend_clr = 1'b0;
		set_used = 1'b0;
		clr_used = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				slot_we = 1'b1;
				slot_waddr = ptr_q;
				slot_wdata = '0;
				val_we = 1'b1;
				val_waddr = ptr_q;
				val_wdata = '0;
				if (ptr_q == LAST_IDX) begin
					ptr_d = '0;
					state_d = S_IDLE;
				end else begin
					ptr_d = ptr_q + IW'(1);
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (req.opcode == OP_CREATE) begin
						state_d = S_ALLOC;
					end else if (req.opcode == OP_SWEEP) begin
						ptr_d = '0;
						pend_clr = 1'b1;
						state_d = S_SW_RD;
					end else begin
						rd_en = 1'b1;
						rd_addr = IW'(req.key_slot);
						state_d = S_EXEC;
					end
				end
			end
			S_ALLOC: begin
				rd_en = 1'b1;
				rd_addr = free_idx_q;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				if (out_free) begin
					rsp_load = 1'b1;
					slot_we = do_create;
					set_used = do_create;
					clr_used = do_delete;
					val_we = do_set;
					state_d = S_IDLE;
				end
			end
			S_SW_RD: begin
				rd_en = 1'b1;
				state_d = S_SW_CHK;
			end
			S_SW_CHK: begin
				// a new hit pushes the held one out, so the held one is not last
				if (!(hit && pend_valid_q) || out_free) begin
					rsp_load = hit && pend_valid_q;
					rsp_d = pend_q;
					pend_load = hit;
					val_we = 1'b1;
					val_waddr = ptr_q;
					val_wdata = '0;
					if (ptr_q == LAST_IDX) begin
						state_d = S_SW_END;
					end else begin
						ptr_d = ptr_q + IW'(1);
						state_d = S_SW_RD;
					end
				end
			end
			S_SW_END: begin
				if (out_free) begin
					rsp_load = 1'b1;
					rsp_d = end_rsp;
					pend_clr = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	assign create_commit = set_used;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ptr_q <= '0;
			used_q <= '0;
			free_idx_q <= '0;
			full_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ptr_q <= ptr_d;
			free_idx_q <= free_idx_d;
			full_q <= &used_q;
			if (set_used) begin
				used_q[free_idx_q] <= 1'b1;
			end
			if (clr_used) begin
				used_q[req_idx] <= 1'b0;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (pend_clr) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
		if (pend_load) begin
			pend_q <= hit_rsp;
		end
	end

	assign rsp_err        = rsp_valid_q && (rsp_q.status != ST_OK);
	assign rsp_payload_ok = (rsp_q.read_value != '0) && (rsp_q.handler != '0);

	`GKT_ASSERT(a_create_marks_used, create_commit |=> used_q[$past(free_idx_q)], "slot not used")
	`GKT_ASSERT(a_found_has_payload, rsp_valid_q && rsp_q.found |-> rsp_payload_ok, "empty sweep item")
	`GKT_ASSERT_NEVER(a_error_not_last, rsp_err && (!rsp_q.last || rsp_q.found), "error item not final")

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for generational_key_table. Requests run through an
// in-bench model of the slot table and value store. Each response is checked
// field by field, in order, against the model's output. Random idle bursts
// are applied on both handshakes.
// ----------------------------------------------------------------------------
module tb;
	import gkt_pkg::*;

	localparam int KEYS         = 64;
	localparam int RANDOM_ITEMS = 430;
	localparam int TAIL_ITEMS   = 60;
	localparam int STALL_LIMIT  = 2000;
	localparam int FIRST_ILLEGAL_OP = int'(OP_SWEEP) + 1;
	localparam int LAST_ILLEGAL_OP  = (1 << OPCODE_W) - 1;

	// Table model plus the queue of responses it predicts.
	class key_table_scoreboard;
		bit                 slot_used[KEYS];
		bit [KGEN_W-1:0]    slot_gen[KEYS];
		bit [HANDLER_W-1:0] slot_handler[KEYS];
		bit [VALUE_W-1:0]   stored_value[KEYS];
		bit [KGEN_W-1:0]    stored_tag[KEYS];
		int                 live_count;
		rsp_t               pending_rsps[$];
		int                 mismatches;
		int                 results_checked;
		int                 full_table_creates;
		int                 swept_slots;
		int                 widest_sweep;
		int                 op_seen[1 << OPCODE_W];

		function int pick_used();
			int start;
			start = $urandom_range(0, KEYS - 1);
			for (int k = 0; k < KEYS; k++)
				if (slot_used[(start + k) % KEYS])
					return (start + k) % KEYS;
			return -1;
		endfunction

		function void note_request(req_t item);
			rsp_t r;
			rsp_t sweep_out[$];
			int   idx;
			int   free_slot;
			idx = int'(item.key_slot);
			op_seen[item.opcode]++;
			r = '0;
			r.last = 1'b1;
			case (item.opcode)
				OP_CREATE: begin
					free_slot = -1;
					for (int i = KEYS - 1; i >= 0; i--)
						if (!slot_used[i])
							free_slot = i;
					if (free_slot < 0) begin
						r.status = ST_NOFREE;
						full_table_creates++;
					end else begin
						slot_handler[free_slot] = item.destructor_handle;
						slot_gen[free_slot] = slot_gen[free_slot] + 1'b1;
						slot_used[free_slot] = 1'b1;
						live_count++;
						r.status = ST_OK;
						r.slot_index = IDX_W'(free_slot);
						r.slot_generation = slot_gen[free_slot];
					end
					pending_rsps.push_back(r);
				end
				OP_DELETE: begin
					if (!slot_used[idx]) begin
						r.status = ST_INVALID;
					end else begin
						// value store is left alone
						slot_used[idx] = 1'b0;
						live_count--;
						r.status = ST_OK;
					end
					pending_rsps.push_back(r);
				end
				OP_SET: begin
					if (!slot_used[idx]) begin
						r.status = ST_INVALID;
					end else begin
						stored_value[idx] = item.value;
						stored_tag[idx] = slot_gen[idx];
						r.status = ST_OK;
					end
					pending_rsps.push_back(r);
				end
				OP_GET: begin
					r.status = ST_OK;
					if (stored_tag[idx] == item.key_generation)
						r.read_value = stored_value[idx];
					pending_rsps.push_back(r);
				end
				OP_SWEEP: begin
					for (int i = 0; i < KEYS; i++) begin
						if (stored_value[i] != '0 && slot_used[i] &&
								stored_tag[i] == slot_gen[i] && slot_handler[i] != '0) begin
							r = '0;
							r.status = ST_OK;
							r.slot_index = IDX_W'(i);
							r.slot_generation = slot_gen[i];
							r.read_value = stored_value[i];
							r.handler = slot_handler[i];
							r.found = 1'b1;
							sweep_out.push_back(r);
						end
						stored_value[i] = '0;
						stored_tag[i] = '0;
					end
					swept_slots += sweep_out.size();
					if (sweep_out.size() > widest_sweep)
						widest_sweep = sweep_out.size();
					if (sweep_out.size() == 0) begin
						r = '0;
						r.last = 1'b1;
						sweep_out.push_back(r);
					end else begin
						r = sweep_out.pop_back();
						r.last = 1'b1;
						sweep_out.push_back(r);
					end
					foreach (sweep_out[k])
						pending_rsps.push_back(sweep_out[k]);
				end
				default: begin
					r.status = ST_INVALID;
					pending_rsps.push_back(r);
				end
			endcase
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $realtime, msg);
			mismatches++;
		endtask

		task compare_field(string name, logic [63:0] got, logic [63:0] want);
			if (got !== want)
				report($sformatf("result %0d %s got %h want %h", results_checked, name,
					got, want));
		endtask

		task check_response(rsp_t got);
			rsp_t want;
			results_checked++;
			if (pending_rsps.size() == 0) begin
				report($sformatf("unexpected result %h", got));
				return;
			end
			want = pending_rsps.pop_front();
			compare_field("status", 64'(got.status), 64'(want.status));
			compare_field("slot_index", 64'(got.slot_index), 64'(want.slot_index));
			compare_field("slot_generation", 64'(got.slot_generation),
				64'(want.slot_generation));
			compare_field("read_value", got.read_value, want.read_value);
			compare_field("handler", 64'(got.handler), 64'(want.handler));
			compare_field("found", 64'(got.found), 64'(want.found));
			compare_field("last", 64'(got.last), 64'(want.last));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	key_table_scoreboard tracker = new();
	bit calm = 1'b0;
	bit drain_next = 1'b0;
	int items_sent = 0;
	int stall_cycles = 0;

	generational_key_table #(.KEYS(KEYS), .GEN_BITS(KGEN_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #2 clk = ~clk;

	function automatic req_t make_req(logic [OPCODE_W-1:0] op, int idx,
			logic [KGEN_W-1:0] kgen, logic [VALUE_W-1:0] value,
			logic [HANDLER_W-1:0] dh);
		req_t item;
		item.opcode = op;
		item.key_slot = IDX_W'(idx);
		item.key_generation = kgen;
		item.value = value;
		item.destructor_handle = dh;
		return item;
	endfunction

	function automatic logic [VALUE_W-1:0] random_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [HANDLER_W-1:0] random_handler();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Mostly well-formed keys taken from live slots, some noise.
	function automatic req_t mixed_item(int create_weight, int delete_weight);
		req_t item;
		int   roll;
		int   slot;
		int   set_limit;
		roll = $urandom_range(0, 99);
		slot = tracker.pick_used();
		if (slot < 0 || $urandom_range(0, 7) == 0)
			slot = $urandom_range(0, KEYS - 1);
		set_limit = create_weight + delete_weight + (93 - create_weight - delete_weight) / 2;
		item = make_req(OP_GET, slot, tracker.slot_gen[slot], random_value(),
			random_handler());
		if (roll < create_weight) begin
			item.opcode = OP_CREATE;
			item.key_generation = KGEN_W'($urandom);
		end else if (roll < create_weight + delete_weight) begin
			item.opcode = OP_DELETE;
		end else if (roll < set_limit) begin
			item.opcode = OP_SET;
		end else if (roll < 93) begin
			case ($urandom_range(0, 7))
				0: item.key_generation = tracker.slot_gen[slot] - 1'b1;
				1: item.key_generation = tracker.stored_tag[slot];
				2: item.key_generation = KGEN_W'($urandom);
				default: ;
			endcase
		end else if (roll < 97) begin
			item.opcode = OP_SWEEP;
		end else begin
			item.opcode = OPCODE_W'($urandom_range(FIRST_ILLEGAL_OP, LAST_ILLEGAL_OP));
			item.key_slot = IDX_W'($urandom);
			item.key_generation = KGEN_W'($urandom);
		end
		return item;
	endfunction

	// Maybe idle or drain first, then hold the item until it is taken.
	task automatic send_item(input req_t item);
		int gap;
		if (drain_next || (!calm && $urandom_range(0, 49) == 0)) begin
			drain_next = 1'b0;
			req_valid <= 1'b0;
			do
				@(posedge clk);
			while (tracker.pending_rsps.size() != 0);
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 18);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do
			@(posedge clk);
		while (!req_ready);
		tracker.note_request(item);
		items_sent++;
	endtask

	// Fill every slot, overflow, tag each with a value, sweep all, drop some.
	task automatic fill_and_sweep();
		logic [VALUE_W-1:0]   v;
		logic [HANDLER_W-1:0] h;
		for (int i = 0; i < KEYS; i++)
			if (tracker.slot_used[i] && tracker.slot_handler[i] == '0)
				send_item(make_req(OP_DELETE, i, tracker.slot_gen[i], '0, '0));
		while (tracker.live_count < KEYS) begin
			do
				h = $urandom;
			while (h == '0);
			send_item(make_req(OP_CREATE, $urandom_range(0, KEYS - 1), KGEN_W'($urandom),
				random_value(), h));
		end
		repeat (2)
			send_item(make_req(OP_CREATE, 0, '0, '0, random_handler()));
		for (int i = 0; i < KEYS; i++) begin
			do
				v = {$urandom, $urandom};
			while (v == '0);
			send_item(make_req(OP_SET, i, tracker.slot_gen[i], v, '0));
		end
		send_item(make_req(OP_SWEEP, 0, '0, '0, '0));
		for (int i = 0; i < KEYS; i++)
			if ($urandom_range(0, 1) == 0)
				send_item(make_req(OP_DELETE, i, tracker.slot_gen[i], '0, '0));
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			tracker.check_response(rsp);
	end

	initial begin
		int n;
		forever begin
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 18);
				rsp_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
			$display("[generational_key_table] ERROR");
			$finish;
		end
	end

	initial begin
		int  random_start;
		int  episode_len;
		int  create_weight;
		int  delete_weight;
		bit  quiet;
		bit  filled;
		filled = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, bad keys, stale gets, sweep rules, bad opcodes
		send_item(make_req(OP_GET, 0, '0, '0, '0));
		send_item(make_req(OP_DELETE, 5, '1, '1, '1));
		send_item(make_req(OP_SET, KEYS - 1, '1, '1, '1));
		send_item(make_req(OP_CREATE, 0, '0, '0, '1));
		send_item(make_req(OP_CREATE, 0, '0, '0, '0));
		send_item(make_req(OP_CREATE, 0, '0, '0, 32'h1));
		send_item(make_req(OP_SET, 0, 16'h1, '1, '0));
		send_item(make_req(OP_SET, 1, 16'h1, 64'h8000_0000_0000_0001, '0));
		send_item(make_req(OP_SET, 2, 16'h1, '0, '0));
		send_item(make_req(OP_GET, 0, 16'h1, '0, '0));
		send_item(make_req(OP_GET, 0, '1, '0, '0));
		send_item(make_req(OP_SWEEP, 0, '0, '0, '0));
		send_item(make_req(OP_GET, 0, 16'h1, '0, '0));
		send_item(make_req(OP_SET, 0, 16'h1, 64'h0123_4567_89ab_cdef, '0));
		send_item(make_req(OP_DELETE, 0, 16'h1, '0, '0));
		send_item(make_req(OP_DELETE, 0, 16'h1, '0, '0));
		send_item(make_req(OP_GET, 0, 16'h1, '0, '0));
		send_item(make_req(OP_SWEEP, 0, '0, '0, '0));
		send_item(make_req(OP_CREATE, 0, '0, '0, 32'ha5a5_a5a5));
		for (int op = FIRST_ILLEGAL_OP; op <= LAST_ILLEGAL_OP; op++)
			send_item(make_req(OPCODE_W'(op), KEYS - 1, '1, '1, '1));
		send_item(make_req(OP_DELETE, KEYS - 1, '1, '0, '0));
		send_item(make_req(OP_GET, KEYS - 1, '0, '0, '0));
		drain_next = 1'b1;

		random_start = items_sent;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			if (!filled && items_sent - random_start >= 60) begin
				fill_and_sweep();
				filled = 1'b1;
			end else begin
				episode_len = $urandom_range(10, 30);
				case ($urandom_range(0, 2))
					0: begin create_weight = 50; delete_weight = 10; end
					1: begin create_weight = 15; delete_weight = 35; end
					default: begin create_weight = 30; delete_weight = 20; end
				endcase
				quiet = ($urandom_range(0, 3) == 0);
				for (int k = 0; k < episode_len && items_sent - random_start < RANDOM_ITEMS;
						k++) begin
					calm = quiet || (items_sent - random_start >= RANDOM_ITEMS - TAIL_ITEMS);
					send_item(mixed_item(create_weight, delete_weight));
				end
			end
		end
		req_valid <= 1'b0;

		while (tracker.pending_rsps.size() != 0)
			@(posedge clk);
		repeat (2 * KEYS + 8) @(posedge clk);
		if (tracker.pending_rsps.size() != 0)
			tracker.report($sformatf("%0d results never arrived",
				tracker.pending_rsps.size()));

		$display("ran %0d requests: %0d create, %0d delete, %0d set, %0d get, %0d sweep",
			items_sent, tracker.op_seen[OP_CREATE], tracker.op_seen[OP_DELETE],
			tracker.op_seen[OP_SET], tracker.op_seen[OP_GET], tracker.op_seen[OP_SWEEP]);
		$display("%0d results checked, %0d creates on a full table, %0d slots swept (widest %0d)",
			tracker.results_checked, tracker.full_table_creates, tracker.swept_slots,
			tracker.widest_sweep);
		if (tracker.mismatches == 0)
			$display("[generational_key_table] OK");
		else
			$display("[generational_key_table] ERROR");
		$finish;
	end

endmodule
